// File: rtl/htw_pkg.sv
// ---------------------------------------------------------------------------
// htw_pkg: shared types and constants of the timing wheel
// Wheel geometry, command and result codes, slot address helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package htw_pkg;

  localparam int NEAR_BITS    = 8;
  localparam int LEVEL_BITS   = 6;
  localparam int LEVELS       = 4;
  localparam int LVL_W        = 2;
  localparam int POOL_ENTRIES = 64;
  localparam int PIDX_W       = 6;              // entry index
  localparam int PTR_W        = PIDX_W + 1;     // entry index or empty code
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);
  localparam int LSLOT_W      = LVL_W + LEVEL_BITS;
  localparam int SLOT_AW      = 1 + ((NEAR_BITS > LSLOT_W) ? NEAR_BITS : LSLOT_W);
  localparam int SLOTS        = 1 << SLOT_AW;

  // command codes from the front part
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_IMM  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_EXPIRED   = 2'd0;
  localparam logic [1:0] KIND_IMMEDIATE = 2'd1;
  localparam logic [1:0] KIND_REJECTED  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] owner;
    logic [31:0] session;
    logic [31:0] timeout;
  } htw_cmd_t;

  typedef struct packed {
    logic     hit;
    logic [SLOT_AW-1:0] addr;
  } htw_casc_t;

  function automatic logic [SLOT_AW-1:0] near_slot(input logic [31:0] t);
    near_slot = SLOT_AW'(t[NEAR_BITS-1:0]);
  endfunction

  function automatic logic [SLOT_AW-1:0] level_slot(input logic [LVL_W-1:0] lvl,
                                                    input logic [LEVEL_BITS-1:0] idx);
    level_slot = (SLOT_AW'(1) << (SLOT_AW - 1)) | SLOT_AW'({lvl, idx});
  endfunction

  // slot for an expiry: near if in the current near window, else lowest level
  // whose window is shared, else the top level
  function automatic logic [SLOT_AW-1:0] file_slot(input logic [31:0] when,
                                                   input logic [31:0] now);
    logic [SLOT_AW-1:0] a;
    a = level_slot(LVL_W'(LEVELS - 1),
                   LEVEL_BITS'(when >> (NEAR_BITS + LEVEL_BITS * (LEVELS - 1))));
    for (int l = LEVELS - 2; l >= 0; l--) begin
      if ((when >> (NEAR_BITS + LEVEL_BITS * (l + 1))) ==
          (now >> (NEAR_BITS + LEVEL_BITS * (l + 1))))
        a = level_slot(LVL_W'(l), LEVEL_BITS'(when >> (NEAR_BITS + LEVEL_BITS * l)));
    end
    if ((when >> NEAR_BITS) == (now >> NEAR_BITS))
      a = near_slot(when);
    file_slot = a;
  endfunction

  // level slot to cascade after the counter has moved to ct
  function automatic htw_casc_t casc_slot(input logic [31:0] ct);
    htw_casc_t c;
    logic [LEVEL_BITS-1:0] idx;
    logic [31:0] low_mask;
    c.hit  = (ct[NEAR_BITS-1:0] == '0);
    c.addr = level_slot(LVL_W'(LEVELS - 1), '0);
    for (int l = LEVELS - 1; l >= 0; l--) begin
      idx      = LEVEL_BITS'(ct >> (NEAR_BITS + LEVEL_BITS * l));
      low_mask = 32'((64'(1) << (NEAR_BITS + LEVEL_BITS * l)) - 64'(1));
      if (((ct & low_mask) == '0) && (idx != '0))
        c.addr = level_slot(LVL_W'(l), idx);
    end
    casc_slot = c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/htw_front.sv
// ---------------------------------------------------------------------------
// htw_front: input acceptance and classification
// Sorts each item into tick, immediate answer or add, and queues it.
// ---------------------------------------------------------------------------
`default_nettype none
module htw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [95:0]       in_tdata,
  input  wire logic              in_tuser,
  output logic                   cmd_valid,
  output htw_pkg::htw_cmd_t      cmd,
  input  wire logic              cmd_pop
);

  htw_pkg::htw_cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  htw_pkg::htw_cmd_t in_cmd;
  logic [31:0] tmo;

  assign tmo       = in_tdata[95:64];
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    in_cmd.owner   = in_tdata[31:0];
    in_cmd.session = in_tdata[63:32];
    in_cmd.timeout = tmo;
    if (in_tuser) begin
      in_cmd.cmd = htw_pkg::CMD_TICK;
    end else if ((tmo == '0) || tmo[31]) begin
      in_cmd.cmd = htw_pkg::CMD_IMM;
    end else begin
      in_cmd.cmd = htw_pkg::CMD_ADD;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("command queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !cmd_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("command queue count lost a push");

endmodule
`default_nettype wire

// File: rtl/htw_back.sv
// ---------------------------------------------------------------------------
// htw_back: wheel sequencer
// Files, fires and cascades timer entries held in slot and entry memories.
// ---------------------------------------------------------------------------
`default_nettype none
module htw_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire htw_pkg::htw_cmd_t cmd,
  output logic                   cmd_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int SAW = htw_pkg::SLOT_AW;
  localparam int PW  = htw_pkg::PTR_W;
  localparam int IW  = htw_pkg::PIDX_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_RD   = 4'd1;
  localparam logic [3:0] S_FILE_RD  = 4'd2;
  localparam logic [3:0] S_FILE     = 4'd3;
  localparam logic [3:0] S_FILE_T   = 4'd4;
  localparam logic [3:0] S_FIRE_CHK = 4'd5;
  localparam logic [3:0] S_FIRE_H   = 4'd6;
  localparam logic [3:0] S_FIRE_USE = 4'd7;
  localparam logic [3:0] S_ADV      = 4'd8;
  localparam logic [3:0] S_CAS_H    = 4'd9;
  localparam logic [3:0] S_CAS_NX   = 4'd10;
  localparam logic [3:0] S_CAS_USE  = 4'd11;
  localparam logic [3:0] S_TEND     = 4'd12;
  localparam logic [3:0] S_CLEAR    = 4'd13;

  // slot memories (near and level share one address space), head NIL = empty
  logic [PW-1:0] head_mem [htw_pkg::SLOTS];
  logic [IW-1:0] tail_mem [htw_pkg::SLOTS];
  // entry memories
  logic [31:0]   exp_mem  [htw_pkg::POOL_ENTRIES];
  logic [31:0]   own_mem  [htw_pkg::POOL_ENTRIES];
  logic [31:0]   ses_mem  [htw_pkg::POOL_ENTRIES];
  logic [PW-1:0] next_mem [htw_pkg::POOL_ENTRIES];
  logic [htw_pkg::POOL_ENTRIES-1:0] next_vld_r;

  // registered read data
  logic [PW-1:0] head_rd_r;
  logic [IW-1:0] tail_rd_r;
  logic [PW-1:0] next_rd_r;
  logic          next_rdv_r;
  logic [31:0]   own_rd_r, ses_rd_r, exp_rd_r;

  // memory controls
  logic           head_re, tail_re, ent_re;
  logic [SAW-1:0] head_ra, tail_ra;
  logic [IW-1:0]  ent_ra;
  logic           head_we, tail_we;
  logic [SAW-1:0] head_wa, tail_wa;
  logic [PW-1:0]  head_wd;
  logic [IW-1:0]  tail_wd;
  logic           next_we, data_we;
  logic [IW-1:0]  next_wa, data_wa;
  logic [PW-1:0]  next_wd;
  logic [31:0]    exp_wd;

  // sequencer state
  logic [3:0]     state_r, state_nxt;
  logic [SAW-1:0] clr_r, clr_nxt;
  logic           phase_r, phase_nxt;
  logic           ret_cas_r, ret_cas_nxt;
  logic [31:0]    tick_r, tick_nxt;
  logic [PW-1:0]  free_head_r, free_head_nxt;
  logic [IW-1:0]  cur_e_r, cur_e_nxt;
  logic [PW-1:0]  nx_r, nx_nxt;
  logic [31:0]    when_r, when_nxt;
  logic [SAW-1:0] slot_r, slot_nxt;
  htw_pkg::htw_cmd_t cmd_r, cmd_nxt;

  logic           pend_vld_r, pend_vld_nxt;
  logic [1:0]     pend_kind_r, pend_kind_nxt;
  logic [31:0]    pend_own_r, pend_own_nxt;
  logic [31:0]    pend_ses_r, pend_ses_nxt;

  logic           out_vld_r, out_vld_nxt;
  logic [1:0]     out_kind_r, out_kind_nxt;
  logic [31:0]    out_own_r, out_own_nxt;
  logic [31:0]    out_ses_r, out_ses_nxt;
  logic           out_last_r, out_last_nxt;

  logic           out_free;
  logic [PW-1:0]  nx_fire;
  logic [SAW-1:0] fslot;
  logic [31:0]    tick_inc;
  htw_pkg::htw_casc_t casc;

  assign out_free   = !out_vld_r || out_tready;
  assign nx_fire    = next_rdv_r ? next_rd_r : (PW'(cur_e_r) + PW'(1));
  assign fslot      = htw_pkg::file_slot(when_r, tick_r);
  assign tick_inc   = tick_r + 32'd1;
  assign casc       = htw_pkg::casc_slot(tick_inc);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_ses_r, out_own_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    phase_nxt     = phase_r;
    ret_cas_nxt   = ret_cas_r;
    tick_nxt      = tick_r;
    free_head_nxt = free_head_r;
    cur_e_nxt     = cur_e_r;
    nx_nxt        = nx_r;
    when_nxt      = when_r;
    slot_nxt      = slot_r;
    cmd_nxt       = cmd_r;
    pend_vld_nxt  = pend_vld_r;
    pend_kind_nxt = pend_kind_r;
    pend_own_nxt  = pend_own_r;
    pend_ses_nxt  = pend_ses_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_own_nxt   = out_own_r;
    out_ses_nxt   = out_ses_r;
    out_last_nxt  = out_last_r;
    cmd_pop = 1'b0;
    head_re = 1'b0; head_ra = slot_r;
    tail_re = 1'b0; tail_ra = slot_r;
    ent_re  = 1'b0; ent_ra  = cur_e_r;
    head_we = 1'b0; head_wa = slot_r; head_wd = htw_pkg::NIL;
    tail_we = 1'b0; tail_wa = slot_r; tail_wd = cur_e_r;
    next_we = 1'b0; next_wa = cur_e_r; next_wd = htw_pkg::NIL;
    data_we = 1'b0; data_wa = cur_e_r; exp_wd = cmd_r.timeout + tick_r;

    case (state_r)
      S_CLEAR: begin
        // mark every slot empty once after reset
        head_we = 1'b1;
        head_wa = clr_r;
        clr_nxt = clr_r + SAW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          case (cmd.cmd)
            htw_pkg::CMD_TICK: begin
              phase_nxt = 1'b0;
              state_nxt = S_FIRE_CHK;
            end
            htw_pkg::CMD_ADD: begin
              if (free_head_r == htw_pkg::NIL) begin
                pend_vld_nxt  = 1'b1;
                pend_kind_nxt = htw_pkg::KIND_REJECTED;
                pend_own_nxt  = cmd.owner;
                pend_ses_nxt  = cmd.session;
                state_nxt     = S_TEND;
              end else begin
                ent_re    = 1'b1;
                ent_ra    = free_head_r[IW-1:0];
                cur_e_nxt = free_head_r[IW-1:0];
                state_nxt = S_ADD_RD;
              end
            end
            default: begin
              pend_vld_nxt  = 1'b1;
              pend_kind_nxt = htw_pkg::KIND_IMMEDIATE;
              pend_own_nxt  = cmd.owner;
              pend_ses_nxt  = cmd.session;
              state_nxt     = S_TEND;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        // pop the free list, store the payload and the expiry
        free_head_nxt = nx_fire;
        data_we       = 1'b1;
        when_nxt      = exp_wd;
        ret_cas_nxt   = 1'b0;
        state_nxt     = S_FILE_RD;
      end
      S_FILE_RD: begin
        slot_nxt  = fslot;
        head_re   = 1'b1;
        head_ra   = fslot;
        tail_re   = 1'b1;
        tail_ra   = fslot;
        state_nxt = S_FILE;
      end
      S_FILE: begin
        next_we = 1'b1;
        if (head_rd_r == htw_pkg::NIL) begin
          head_we   = 1'b1;
          head_wd   = PW'(cur_e_r);
          tail_we   = 1'b1;
          state_nxt = ret_cas_r ? S_CAS_NX : S_IDLE;
        end else begin
          state_nxt = S_FILE_T;
        end
      end
      S_FILE_T: begin
        next_we   = 1'b1;
        next_wa   = tail_rd_r;
        next_wd   = PW'(cur_e_r);
        tail_we   = 1'b1;
        state_nxt = ret_cas_r ? S_CAS_NX : S_IDLE;
      end
      S_FIRE_CHK: begin
        slot_nxt  = htw_pkg::near_slot(tick_r);
        head_re   = 1'b1;
        head_ra   = htw_pkg::near_slot(tick_r);
        state_nxt = S_FIRE_H;
      end
      S_FIRE_H: begin
        if (head_rd_r == htw_pkg::NIL) begin
          state_nxt = phase_r ? S_TEND : S_ADV;
        end else begin
          head_we   = 1'b1;
          ent_re    = 1'b1;
          ent_ra    = head_rd_r[IW-1:0];
          cur_e_nxt = head_rd_r[IW-1:0];
          state_nxt = S_FIRE_USE;
        end
      end
      S_FIRE_USE: begin
        // hold the read data until the older result can move on
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = pend_kind_r;
            out_own_nxt  = pend_own_r;
            out_ses_nxt  = pend_ses_r;
            out_last_nxt = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_kind_nxt = htw_pkg::KIND_EXPIRED;
          pend_own_nxt  = own_rd_r;
          pend_ses_nxt  = ses_rd_r;
          next_we       = 1'b1;
          next_wd       = free_head_r;
          free_head_nxt = PW'(cur_e_r);
          if (nx_fire == htw_pkg::NIL) begin
            state_nxt = phase_r ? S_TEND : S_ADV;
          end else begin
            ent_re    = 1'b1;
            ent_ra    = nx_fire[IW-1:0];
            cur_e_nxt = nx_fire[IW-1:0];
          end
        end
      end
      S_ADV: begin
        tick_nxt  = tick_inc;
        phase_nxt = 1'b1;
        slot_nxt  = casc.addr;
        if (casc.hit) begin
          head_re     = 1'b1;
          head_ra     = casc.addr;
          ret_cas_nxt = 1'b1;
          state_nxt   = S_CAS_H;
        end else begin
          state_nxt = S_FIRE_CHK;
        end
      end
      S_CAS_H: begin
        // detach the whole list, then walk it from the saved link
        if (head_rd_r == htw_pkg::NIL) begin
          state_nxt = S_FIRE_CHK;
        end else begin
          head_we   = 1'b1;
          nx_nxt    = head_rd_r;
          state_nxt = S_CAS_NX;
        end
      end
      S_CAS_NX: begin
        if (nx_r == htw_pkg::NIL) begin
          state_nxt = S_FIRE_CHK;
        end else begin
          ent_re    = 1'b1;
          ent_ra    = nx_r[IW-1:0];
          cur_e_nxt = nx_r[IW-1:0];
          state_nxt = S_CAS_USE;
        end
      end
      S_CAS_USE: begin
        nx_nxt    = nx_fire;
        when_nxt  = exp_rd_r;
        state_nxt = S_FILE_RD;
      end
      S_TEND: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_own_nxt  = pend_own_r;
          out_ses_nxt  = pend_ses_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      phase_r     <= 1'b0;
      ret_cas_r   <= 1'b0;
      tick_r      <= '0;
      free_head_r <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      next_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      phase_r     <= phase_nxt;
      ret_cas_r   <= ret_cas_nxt;
      tick_r      <= tick_nxt;
      free_head_r <= free_head_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      if (next_we) next_vld_r[next_wa] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_e_r     <= cur_e_nxt;
    nx_r        <= nx_nxt;
    when_r      <= when_nxt;
    slot_r      <= slot_nxt;
    cmd_r       <= cmd_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_own_r  <= pend_own_nxt;
    pend_ses_r  <= pend_ses_nxt;
    out_kind_r  <= out_kind_nxt;
    out_own_r   <= out_own_nxt;
    out_ses_r   <= out_ses_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (head_re) head_rd_r <= head_mem[head_ra];
    if (tail_re) tail_rd_r <= tail_mem[tail_ra];
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (data_we) begin
      exp_mem[data_wa] <= exp_wd;
      own_mem[data_wa] <= cmd_r.owner;
      ses_mem[data_wa] <= cmd_r.session;
    end
    if (next_we) next_mem[next_wa] <= next_wd;
    if (ent_re) begin
      exp_rd_r   <= exp_mem[ent_ra];
      own_rd_r   <= own_mem[ent_ra];
      ses_rd_r   <= ses_mem[ent_ra];
      next_rd_r  <= next_mem[ent_ra];
      next_rdv_r <= next_vld_r[ent_ra];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == S_FILE_T |-> head_rd_r != htw_pkg::NIL)
    else $error("tail append on an empty slot");
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == S_IDLE |-> !pend_vld_r)
    else $error("held result left behind at idle");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_TEND) |-> (phase_r || cmd_r.cmd != htw_pkg::CMD_TICK))
    else $error("tick ended before its second fire");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_vld_r && !out_tready) |=>
                   (out_vld_r && $stable(out_tdata) && $stable(out_tuser) &&
                    $stable(out_tlast)))
    else $error("result changed while waiting");

endmodule
`default_nettype wire

// File: rtl/hierarchical_timing_wheel.sv
// ---------------------------------------------------------------------------
// hierarchical_timing_wheel: timer engine top level
// Front queue of classified items feeding the wheel sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tuser      | tlast
//  in_     | in  | owner_handle, session, timeout_ticks    | action     | -
//  out_    | out | owner_handle_out, session_out           | kind       | last
//
//  A filed add takes an extra append step when it joins a non-empty slot.
//  A tick fires its entries one at a time, set by the single entry memory
//  port; a cascade re-files the entries of its level slot one by one.
//  Reset is synchronous and starts a clearing pass that marks every slot
//  empty; the front takes up to two transfers meanwhile.
//  Results wait in a held register and then an output register; the
//  sequencer holds when both are full.
`default_nettype none
module hierarchical_timing_wheel (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // owner_handle, session, timeout_ticks
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // owner_handle_out, session_out
  output logic [1:0]       out_tuser,  // kind
  output logic             out_tlast
);

  logic              cmd_valid;
  logic              cmd_pop;
  htw_pkg::htw_cmd_t cmd;

  // classify and queue each transfer
  htw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // file, fire and cascade
  htw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: test/tb_hierarchical_timing_wheel.sv
// ---------------------------------------------------------------------------
// tb_hierarchical_timing_wheel: self-checking bench for the timer engine
// Drives add and tick transfers with random gaps, predicts every expiry,
// immediate answer and pool-full reject, and checks the result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_hierarchical_timing_wheel;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NEAR_BITS    = htw_pkg::NEAR_BITS;
  localparam int LEVEL_BITS   = htw_pkg::LEVEL_BITS;
  localparam int LEVELS       = htw_pkg::LEVELS;
  localparam int POOL_ENTRIES = htw_pkg::POOL_ENTRIES;
  localparam int PTR_W        = htw_pkg::PTR_W;
  localparam logic [PTR_W-1:0] NIL = htw_pkg::NIL;
  localparam int NSLOT = 1 << NEAR_BITS;
  localparam int LSLOT = 1 << LEVEL_BITS;
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] owner;
    logic [31:0] session;
    logic [31:0] timeout;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] owner;
    logic [31:0] session;
    logic        last;
  } timer_note_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  hierarchical_timing_wheel i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Wheel shadow: tick counter, slot lists and entry pool
  // -------------------------------------------------------------------------
  logic [31:0]      wheel_now;
  logic [PTR_W-1:0] near_head [NSLOT];
  logic [PTR_W-1:0] near_tail [NSLOT];
  logic [PTR_W-1:0] lvl_head [LEVELS*LSLOT];
  logic [PTR_W-1:0] lvl_tail [LEVELS*LSLOT];
  logic [31:0]      ent_when [POOL_ENTRIES];
  logic [31:0]      ent_owner [POOL_ENTRIES];
  logic [31:0]      ent_sess [POOL_ENTRIES];
  logic [PTR_W-1:0] ent_next [POOL_ENTRIES];
  logic [PTR_W-1:0] free_ptr;

  timer_req_t  pending_reqs[$];
  timer_note_t expected_notes[$];
  bit          failed = 0;
  int          live_timers = 0;

  function automatic void wheel_reset();
    wheel_now = '0;
    for (int i = 0; i < NSLOT; i++) begin
      near_head[i] = NIL;
      near_tail[i] = NIL;
    end
    for (int i = 0; i < LEVELS*LSLOT; i++) begin
      lvl_head[i] = NIL;
      lvl_tail[i] = NIL;
    end
    for (int i = 0; i < POOL_ENTRIES; i++) ent_next[i] = PTR_W'(i + 1);
    free_ptr = '0;
  endfunction

  // append entry e to the near (is_near) or level list at index s
  function automatic void link_entry(bit is_near, int s, logic [PTR_W-1:0] e);
    ent_next[e] = NIL;
    if (is_near) begin
      if (near_head[s] == NIL) near_head[s] = e;
      else ent_next[near_tail[s]] = e;
      near_tail[s] = e;
    end else begin
      if (lvl_head[s] == NIL) lvl_head[s] = e;
      else ent_next[lvl_tail[s]] = e;
      lvl_tail[s] = e;
    end
  endfunction

  // place an entry by its expiry: near window first, else lowest shared level
  function automatic void place_entry(logic [PTR_W-1:0] e);
    logic [31:0] w;
    int lv;
    w = ent_when[e];
    if ((w >> NEAR_BITS) == (wheel_now >> NEAR_BITS)) begin
      link_entry(1, int'(w[NEAR_BITS-1:0]), e);
      return;
    end
    lv = LEVELS - 1;
    for (int l = 0; l < LEVELS - 1; l++) begin
      if ((64'(w) >> (NEAR_BITS + LEVEL_BITS*(l+1))) ==
          (64'(wheel_now) >> (NEAR_BITS + LEVEL_BITS*(l+1)))) begin
        lv = l;
        break;
      end
    end
    link_entry(0, lv*LSLOT + int'((64'(w) >> (NEAR_BITS + LEVEL_BITS*lv)) & (LSLOT-1)), e);
  endfunction

  function automatic void redistribute(int lv, int idx);
    logic [PTR_W-1:0] e, nx;
    int s;
    s = lv*LSLOT + idx;
    e = lvl_head[s];
    lvl_head[s] = NIL;
    lvl_tail[s] = NIL;
    while (e != NIL) begin
      nx = ent_next[e];
      place_entry(e);
      e = nx;
    end
  endfunction

  // release the current near slot, queueing one expiry per entry
  function automatic void expire_slot();
    logic [PTR_W-1:0] e, nx;
    int s;
    s = int'(wheel_now[NEAR_BITS-1:0]);
    e = near_head[s];
    near_head[s] = NIL;
    near_tail[s] = NIL;
    while (e != NIL) begin
      nx = ent_next[e];
      expected_notes.push_back('{htw_pkg::KIND_EXPIRED, ent_owner[e], ent_sess[e], 1'b0});
      ent_next[e] = free_ptr;
      free_ptr = e;
      live_timers--;
      e = nx;
    end
  endfunction

  function automatic void step_counter();
    logic [63:0] t;
    int idx;
    wheel_now = wheel_now + 1;
    t = 64'(wheel_now) >> NEAR_BITS;
    for (int l = 0; l < LEVELS; l++) begin
      if ((64'(wheel_now) & ((64'(1) << (NEAR_BITS + LEVEL_BITS*l)) - 1)) != 0) return;
      idx = int'(t & (LSLOT-1));
      if (idx != 0) begin
        redistribute(l, idx);
        return;
      end
      t = t >> LEVEL_BITS;
    end
    redistribute(LEVELS - 1, 0);
  endfunction

  function automatic void predict_timer(timer_req_t r);
    int prior_cnt;
    logic [PTR_W-1:0] e;
    if (r.action == ACT_ADD) begin
      if (r.timeout == 0 || r.timeout[31])
        expected_notes.push_back('{htw_pkg::KIND_IMMEDIATE, r.owner, r.session, 1'b1});
      else if (free_ptr == NIL)
        expected_notes.push_back('{htw_pkg::KIND_REJECTED, r.owner, r.session, 1'b1});
      else begin
        e = free_ptr;
        free_ptr = ent_next[e];
        ent_owner[e] = r.owner;
        ent_sess[e] = r.session;
        ent_when[e] = wheel_now + r.timeout;
        live_timers++;
        place_entry(e);
      end
    end else begin
      prior_cnt = expected_notes.size();
      expire_slot();
      step_counter();
      expire_slot();
      if (expected_notes.size() > prior_cnt) expected_notes[$].last = 1'b1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Driver: pop pending requests, draw a gap before each transfer
  // -------------------------------------------------------------------------
  int  send_gap = 0;
  bit  stim_done = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_timer(pending_reqs.pop_front());
      if (!(in_tvalid && !in_tready)) begin
        // hold valid high when the next transfer follows back to back
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          timer_req_t nx;
          nx = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tuser <= nx.action;
          in_tdata <= {nx.timeout, nx.session, nx.owner};
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction
  // -------------------------------------------------------------------------
  int recv_gap = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    int g;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_notes.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%h last=%b", $time,
                   out_tuser, out_tdata, out_tlast);
          failed = 1;
        end else begin
          timer_note_t x;
          x = expected_notes.pop_front();
          if (out_tuser !== x.kind || out_tdata !== {x.session, x.owner} ||
              out_tlast !== x.last) begin
            $display("%0t: mismatch expected kind=%0d owner=%h session=%h last=%b",
                     $time, x.kind, x.owner, x.session, x.last);
            $display("%0t:          actual   kind=%0d owner=%h session=%h last=%b",
                     $time, out_tuser, out_tdata[31:0], out_tdata[63:32], out_tlast);
            failed = 1;
          end
        end
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        recv_gap <= g;
        out_tready <= (g == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      // watchdog: count cycles without any transfer
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else if (!(stim_done && expected_notes.size() == 0)) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic timer_req_t add_req(logic [31:0] tmo);
    return '{ACT_ADD, $urandom, $urandom, tmo};
  endfunction

  function automatic timer_req_t tick_req();
    return '{ACT_TICK, $urandom, $urandom, $urandom};
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_notes.size() != 0)
      @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int n;
    wheel_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, immediate answers, short timers
    pending_reqs.push_back('{ACT_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000});
    pending_reqs.push_back('{ACT_ADD, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_reqs.push_back('{ACT_ADD, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_reqs.push_back('{ACT_ADD, 32'h1234_5678, 32'h0000_0000, 32'h0000_0001});
    pending_reqs.push_back('{ACT_ADD, 32'h0F0F_F0F0, 32'h5555_AAAA, 32'h0000_0001});
    pending_reqs.push_back('{ACT_ADD, $urandom, $urandom, 32'h0000_0002});
    pending_reqs.push_back(add_req(32'h7FFF_FFFF));       // far top level, wraps later
    pending_reqs.push_back(add_req(32'd300));             // level 0
    pending_reqs.push_back(add_req(32'd20000));           // level 1
    repeat (4) pending_reqs.push_back(tick_req());
    // fill the pool to force rejects
    for (int i = 0; i < 60; i++) pending_reqs.push_back(add_req($urandom_range(1, 8)));
    pending_reqs.push_back(add_req(32'd5));
    pending_reqs.push_back(add_req(32'd6));
    // pause the sender until the wheel is quiet
    stim_done = 0;
    wait_drained();
    // drain the filled pool with ticks
    repeat (10) pending_reqs.push_back(tick_req());
    wait_drained();

    // random: mostly short timers among ticks, some long and immediate
    n = 0;
    while (n < 45) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) pending_reqs.push_back(tick_req());
      else if (r < 8) pending_reqs.push_back(add_req($urandom_range(1, 30)));
      else if (r < 9) pending_reqs.push_back(add_req($urandom_range(1, 600)));
      else pending_reqs.push_back(add_req($urandom | 32'h8000_0000));
      n++;
      if (n == 20) wait_drained();
    end

    wait_drained();
    stim_done = 1;
    repeat (200) @(posedge clk);
    if (!failed && expected_notes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
